// ===== design/klbs_pkg.sv =====
package klbs_pkg;

  localparam int LedCountDefault = 16;
  localparam logic [31:0] ScanStep = 32'd75;

  typedef enum logic [1:0] {
    CMD_MASK  = 2'd0,
    CMD_BLINK = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_LARGEST = 1'd0,
    REG_REMAP   = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] set_mask;
    logic [15:0] clear_mask;
    logic [15:0] on_time;
    logic [15:0] off_time;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       frame_valid;
    logic [7:0] frame_byte;
    logic [1:0] row_index;
  } out_item_t;

  function automatic logic [15:0] board_remap(input logic [15:0] m);
    logic [15:0] r;
    r = m & 16'hC000;
    if (m[0])  r = r | 16'h0002;
    if (m[1])  r = r | 16'h0008;
    if (m[2])  r = r | 16'h0100;
    if (m[3])  r = r | 16'h0200;
    if (m[4])  r = r | 16'h0040;
    if (m[5])  r = r | 16'h0080;
    if (m[6])  r = r | 16'h0020;
    if (m[7])  r = r | 16'h0010;
    if (m[8])  r = r | 16'h0400;
    if (m[9])  r = r | 16'h0800;
    if (m[10]) r = r | 16'h1000;
    if (m[11]) r = r | 16'h2000;
    if (m[12]) r = r | 16'h0001;
    if (m[13]) r = r | 16'h0004;
    return r;
  endfunction

endpackage

// ===== design/key_led_matrix_blink_scanner.sv =====
// Channel | valid    | stall    | payload
// in      | in_valid | in_stall | in_data  (klbs_pkg::in_item_t)
// out     | out_valid| out_stall| out_data (klbs_pkg::out_item_t)
// cfg     | cfg_we   | -        | cfg_index, cfg_data
//
// Flow: mask and blink commands walk all LED_COUNT entries, each entry read,
// then written back. A tick reads each entry; on each lit blinking LED it
// divides the timer by 10 by constant multiply, runs a 32-step restoring mod
// by on+off and writes back, and it leaves the other entries as they are.
// Rejected and unused commands go straight to the done state.
// Reset: a clearing pass writes zero to all LED_COUNT entries after reset,
// while no item is taken. One output register decouples the sides; a new
// item is taken while a result waits, but the next result stalls in place
// until the output register is free.
module key_led_matrix_blink_scanner #(
  parameter int LED_COUNT = klbs_pkg::LedCountDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  klbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output klbs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import klbs_pkg::*;

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IW:0] LastIdx = (IW+1)'(LED_COUNT - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // entry: {timer, off, on}
  typedef struct packed {
    logic [31:0] timer;
    logic [15:0] off_ms;
    logic [15:0] on_ms;
  } entry_t;

  entry_t mem [LED_COUNT];
  entry_t rd_data;
  logic   mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t mem_wdata;

  state_t state;
  logic [IW:0] idx;
  in_item_t item;
  logic [15:0] largest_key_value;
  logic toggle_remap;
  logic [15:0] lit_mask;
  logic [15:0] shown;
  logic [15:0] bmask;
  logic [1:0] scan_row;
  logic acc;
  out_item_t out_reg;
  logic out_full;
  logic done_fire;

  // divider
  logic [31:0] quo;
  logic [16:0] rem;
  logic [16:0] period;
  logic [5:0]  dstep;

  logic [IW-1:0] ridx;
  assign ridx = idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[ridx];
  end

  // timer / 10 = (timer * 0xCCCCCCCD) >> 35
  logic [63:0] q_full;
  assign q_full = rd_data.timer * 32'hCCCC_CCCD;

  logic led_active;
  assign led_active = lit_mask[ridx] && (rd_data.on_ms != 16'd0);

  logic [17:0] rem_sh;
  assign rem_sh = {rem, quo[31]};

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = ridx;
    mem_wdata = rd_data;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wdata = '0;
    end else if (state == S_EVAL) begin
      if (cmd_t'(item.cmd) == CMD_MASK) begin
        if ((item.set_mask[ridx] | item.clear_mask[ridx]) != 1'b0) begin
          mem_we = 1'b1;
          mem_wdata = '0;
        end
      end else if (cmd_t'(item.cmd) == CMD_BLINK) begin
        mem_we = 1'b1;
        if (bmask[ridx]) begin
          mem_wdata.on_ms = item.on_time;
          mem_wdata.off_ms = item.off_time;
          mem_wdata.timer = '0;
        end else begin
          mem_wdata.on_ms = '0;
          mem_wdata.off_ms = '0;
        end
      end
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
      mem_wdata.timer = rd_data.timer + ScanStep;
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_valid = out_full;
  assign out_data = out_reg;
  assign done_fire = (state == S_DONE) && (!out_full || !out_stall);

  logic [15:0] m_rm;
  assign m_rm = toggle_remap ? board_remap(in_data.set_mask) : in_data.set_mask;

  // command passes the key limit (and a blink mask is not empty); a tick always passes, an unused command never
  logic cmd_ok;
  always_comb begin
    case (cmd_t'(in_data.cmd))
      CMD_MASK:  cmd_ok = (in_data.set_mask <= largest_key_value) &&
                          (in_data.clear_mask <= largest_key_value);
      CMD_BLINK: cmd_ok = (m_rm <= largest_key_value) && (m_rm != 16'd0);
      CMD_TICK:  cmd_ok = 1'b1;
      default:   cmd_ok = 1'b0;
    endcase
  end

  logic [7:0] window;
  always_comb begin
    window = 8'((shown >> {scan_row, 2'b00}) & 16'h00FF);
  end

  logic [3:0] row_bit;
  assign row_bit = (window != 8'd0) ? (4'd1 << scan_row) : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      largest_key_value <= 16'hFFFF;
      toggle_remap <= 1'b0;
      lit_mask <= '0;
      scan_row <= '0;
      out_full <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LARGEST: largest_key_value <= cfg_data;
          REG_REMAP:   toggle_remap <= cfg_data[0];
          default: ;
        endcase
      end
      if (done_fire) out_full <= 1'b1;
      else if (out_full && !out_stall) out_full <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (idx == LastIdx) begin
            idx <= '0;
            state <= S_IDLE;
          end else idx <= idx + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            idx <= '0;
            bmask <= m_rm;
            shown <= lit_mask;
            acc <= cmd_ok;
            state <= cmd_ok ? S_READ : S_DONE;
            if (cmd_ok) begin
              case (cmd_t'(in_data.cmd))
                CMD_MASK:  lit_mask <= (lit_mask | in_data.set_mask) & ~in_data.clear_mask;
                CMD_BLINK: lit_mask <= lit_mask | m_rm;
                default: ;
              endcase
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (cmd_t'(item.cmd) == CMD_TICK && led_active) begin
            quo <= {3'b000, q_full[63:35]};
            rem <= '0;
            period <= {1'b0, rd_data.on_ms} + {1'b0, rd_data.off_ms};
            dstep <= '0;
            state <= S_DIV;
          end else if (idx == LastIdx) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_DIV: begin
          // restoring step: remainder bits only, quotient discarded
          if (rem_sh >= {1'b0, period}) rem <= 17'(rem_sh - {1'b0, period});
          else rem <= rem_sh[16:0];
          quo <= {quo[30:0], 1'b0};
          dstep <= dstep + 1'b1;
          if (dstep == 6'd31) state <= S_WRITE;
        end
        S_WRITE: begin
          if (rem > {1'b0, rd_data.on_ms}) shown[ridx] <= 1'b0;
          if (idx == LastIdx) state <= S_DONE;
          else begin
            idx <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            state <= S_IDLE;
            if (cmd_t'(item.cmd) == CMD_TICK) begin
              out_reg <= '{acc, 1'b1, {~window[3:0], row_bit}, scan_row};
              scan_row <= scan_row + 1'b1;
            end else begin
              out_reg <= '{acc, 1'b0, 8'd0, 2'd0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_tick_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_valid) |-> out_data.accepted)
    else $error("frame without accept");
`endif

endmodule
